### sv/gcsa_pkg.sv
`default_nettype none
package gcsa_pkg;

    localparam int COEF_W   = 18;
    localparam int NUM_REGS = 8;
    localparam int PADDR_W  = 5;
    localparam int BIN_W    = 2;
    localparam int AXIS_W   = 2;
    localparam int PH_W     = 4;
    localparam int ACC_W    = 64;
    localparam int CNT_W    = 32;
    localparam int OUT_DW   = 2 * ACC_W + CNT_W;
    localparam int OUT_UW   = BIN_W + 2 * AXIS_W;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 18'sd0;

    // sequencer phases within one resonator slot
    localparam logic [PH_W-1:0] PH_MUL_C  = 4'd0;
    localparam logic [PH_W-1:0] PH_MUL_S  = 4'd1;
    localparam logic [PH_W-1:0] PH_ADD_X  = 4'd2;
    localparam logic [PH_W-1:0] PH_SUB_P2 = 4'd3;
    localparam logic [PH_W-1:0] PH_FORM_A = 4'd4;
    localparam logic [PH_W-1:0] PH_ACC0   = 4'd5;
    localparam logic [PH_W-1:0] PH_ACC2   = 4'd7;
    localparam logic [PH_W-1:0] PH_ACC4   = 4'd9;
    localparam logic [PH_W-1:0] PH_LAST   = 4'd10;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic clr;
        logic rd;
        logic wr;
        logic wr_im;
    } t_acc_ctl;

endpackage
`default_nettype wire

### sv/goertzel_cross_spectrum_accumulator.sv
`default_nettype none
// Multi-bin Goertzel cross-spectrum accumulator for 3-axis samples. A sample beat
// (tuser 0) runs every bin and axis resonator through one shared multiplier, one
// resonator slot at a time, with tready low throughout. A clear beat has tuser 1.
// A read beat (tuser 2) emits NUM_BINS*9 beats in bin, row, column order, each
// an accumulator read followed by an output beat, tlast on the final one. Values
// out are twice the accumulators, saturated. tuser 3 is accepted and ignored.
// Coefficients are to be written over APB only while idle; the block itself does
// not enforce this.
module goertzel_cross_spectrum_accumulator #(
    parameter int NUM_BINS        = 4,
    parameter int SAMPLE_WIDTH    = 16,
    parameter int RESONATOR_WIDTH = 48
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_s_tvalid,
    output logic                                           o_s_tready,
    // sample_x, sample_y, sample_z (low to high), zero padded to bytes
    input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // command
    input  wire logic [1:0]                                i_s_tuser,
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    // real_part, imag_part, sample_count (low to high)
    output logic [gcsa_pkg::OUT_DW-1:0]                    o_m_tdata,
    // bin_index, row_axis, col_axis (low to high)
    output logic [gcsa_pkg::OUT_UW-1:0]                    o_m_tuser,
    output logic                                           o_m_tlast,
    input  wire logic                                      i_psel,
    input  wire logic                                      i_penable,
    input  wire logic                                      i_pwrite,
    input  wire logic [gcsa_pkg::PADDR_W-1:0]              i_paddr,
    input  wire logic [31:0]                               i_pwdata,
    output logic [31:0]                                    o_prdata,
    output logic                                           o_pready
);
    import gcsa_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int RW   = RESONATOR_WIDTH;
    localparam int AW   = (SW > COEF_W) ? SW : COEF_W;
    localparam int NRES = NUM_BINS * 3;
    localparam int NACC = NUM_BINS * 9;
    localparam int IW   = $clog2(NRES);
    localparam int EW   = $clog2(NACC);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SAMPLE = 5'b00010,
        ST_FLUSH  = 5'b00100,
        ST_RD_REQ = 5'b01000,
        ST_RD_OUT = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [BIN_W-1:0]         r_bin;
    logic [AXIS_W-1:0]        r_axis, r_row, row_s, row_sel, x_idx;
    logic [PH_W-1:0]          r_ph;
    logic signed [COEF_W-1:0] r_coef [NUM_REGS];
    logic signed [RW-1:0]     r_prev [NRES];
    logic signed [RW-1:0]     r_prev2 [NRES];
    logic signed [SW-1:0]     r_x [3];
    logic signed [RW-1:0]     r_t, r_cp, r_b, r_u, r_ns, r_a, ns_c;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_wr_v, r_wr_im;
    logic [EW-1:0]            r_wr_addr, e_addr;
    logic [IW-1:0]            res_i;
    logic signed [RW-1:0]     p1, p2;
    logic signed [COEF_W-1:0] c_sel, s_sel;
    logic signed [SW-1:0]     x_sel;
    logic signed [AW-1:0]     mac_a;
    logic signed [RW-1:0]     mac_b;
    logic                     mac_neg, issue, s_acc, last_slot, last_rd;
    logic signed [RW-1:0]     r15, r16;
    logic signed [63:0]       p64, rd_re, rd_im, rd_sel, wr_data;
    t_acc_ctl                 acc_ctl;
    logic                     cfg_wr;

    function automatic logic signed [RW-1:0] sat_r(input logic signed [RW:0] v);
        if (v[RW] == v[RW-1]) begin
            return v[RW-1:0];
        end
        return v[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        if (v[64] == v[63]) begin
            return v[63:0];
        end
        return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    // configuration
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = {{(32-COEF_W){1'b0}}, r_coef[i_paddr[PADDR_W-1:2]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= (i % 2 == 0) ? COEF_ONE : COEF_ZERO;
            end
        end else if (cfg_wr) begin
            r_coef[i_paddr[PADDR_W-1:2]] <= i_pwdata[COEF_W-1:0];
        end
    end

    // operand selection
    always_comb begin
        unique case (r_ph)
            PH_ACC0, PH_ACC0 + 4'd1: row_s = AXIS_X;
            PH_ACC2, PH_ACC2 + 4'd1: row_s = AXIS_Y;
            default:                 row_s = AXIS_Z;
        endcase
    end

    assign row_sel  = (r_state == ST_SAMPLE) ? row_s : r_row;
    assign e_addr   = EW'(int'(r_bin) * 9 + int'(row_sel) * 3 + int'(r_axis));
    assign res_i    = IW'(int'(r_bin) * 3 + int'(r_axis));
    assign p1       = r_prev[res_i];
    assign p2       = r_prev2[res_i];
    assign c_sel    = r_coef[{r_bin, 1'b0}];
    assign s_sel    = r_coef[{r_bin, 1'b1}];
    assign x_idx    = (r_ph == PH_ADD_X) ? r_axis : row_s;
    assign x_sel    = r_x[x_idx];
    assign s_acc    = r_ph >= PH_ACC0;
    assign issue    = (r_state == ST_SAMPLE) && s_acc;
    assign mac_neg  = ~r_ph[0];
    assign ns_c     = sat_r((RW+1)'(r_u) - (RW+1)'(p2));
    assign last_slot = (r_bin == BIN_LAST) && (r_axis == AXIS_Z);
    assign last_rd  = (r_bin == BIN_LAST) && (r_row == AXIS_Z) && (r_axis == AXIS_Z);

    always_comb begin
        unique case (r_ph)
            PH_MUL_C: mac_a = AW'(c_sel);
            PH_MUL_S: mac_a = AW'(s_sel);
            default:  mac_a = AW'(x_sel);
        endcase
        if (r_ph == PH_MUL_C || r_ph == PH_MUL_S) begin
            mac_b = p1;
        end else begin
            mac_b = r_ph[0] ? r_a : r_b;
        end
    end

    gcsa_mac #(
        .A_W (AW),
        .B_W (RW)
    ) u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_neg (mac_neg),
        .o_r15 (r15),
        .o_r16 (r16),
        .o_p64 (p64)
    );

    assign rd_sel  = r_wr_im ? rd_im : rd_re;
    assign wr_data = sat64(65'(rd_sel) + 65'(p64));

    always_comb begin
        acc_ctl.clr   = (r_state == ST_IDLE) && i_s_tvalid && (i_s_tuser == CMD_CLEAR);
        acc_ctl.rd    = issue || (r_state == ST_RD_REQ);
        acc_ctl.wr    = r_wr_v;
        acc_ctl.wr_im = r_wr_im;
    end

    gcsa_accmem #(
        .DEPTH (NACC),
        .AW    (EW)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (acc_ctl),
        .i_rd_addr (e_addr),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (wr_data),
        .o_rd_re   (rd_re),
        .o_rd_im   (rd_im)
    );

    // datapath registers within a slot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_x[0] <= i_s_tdata[SW-1:0];
            r_x[1] <= i_s_tdata[2*SW-1:SW];
            r_x[2] <= i_s_tdata[3*SW-1:2*SW];
        end
        if (r_state == ST_SAMPLE) begin
            unique case (r_ph)
                PH_MUL_S: begin
                    r_t  <= r15;
                    r_cp <= r16;
                end
                PH_ADD_X: begin
                    r_b <= r16;
                    r_u <= sat_r((RW+1)'(x_sel) + (RW+1)'(r_t));
                end
                PH_SUB_P2: r_ns <= ns_c;
                PH_FORM_A: r_a  <= sat_r((RW+1)'(r_ns) - (RW+1)'(r_cp));
                default: ;
            endcase
        end
        r_wr_addr <= e_addr;
        r_wr_im   <= mac_neg;
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bin   <= '0;
            r_axis  <= AXIS_X;
            r_row   <= AXIS_X;
            r_ph    <= PH_MUL_C;
            r_cnt   <= '0;
            r_wr_v  <= 1'b0;
            for (int i = 0; i < NRES; i++) begin
                r_prev[i]  <= '0;
                r_prev2[i] <= '0;
            end
        end else begin
            r_wr_v <= issue;
            unique case (r_state)
                ST_IDLE: begin
                    r_bin  <= '0;
                    r_axis <= AXIS_X;
                    r_row  <= AXIS_X;
                    r_ph   <= PH_MUL_C;
                    if (i_s_tvalid) begin
                        case (i_s_tuser)
                            CMD_SAMPLE: r_state <= ST_SAMPLE;
                            CMD_CLEAR: begin
                                r_cnt <= '0;
                                for (int i = 0; i < NRES; i++) begin
                                    r_prev[i]  <= '0;
                                    r_prev2[i] <= '0;
                                end
                            end
                            CMD_READ: r_state <= ST_RD_REQ;
                            default: ;
                        endcase
                    end
                end
                ST_SAMPLE: begin
                    if (r_ph == PH_SUB_P2) begin
                        r_prev2[res_i] <= p1;
                        r_prev[res_i]  <= ns_c;
                    end
                    if (r_ph == PH_LAST) begin
                        r_ph <= PH_MUL_C;
                        if (last_slot) begin
                            r_state <= ST_FLUSH;
                        end else if (r_axis == AXIS_Z) begin
                            r_axis <= AXIS_X;
                            r_bin  <= r_bin + 1'b1;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    if (~&r_cnt) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                ST_RD_REQ: r_state <= ST_RD_OUT;
                ST_RD_OUT: begin
                    if (i_m_tready) begin
                        if (last_rd) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_RD_REQ;
                            if (r_axis != AXIS_Z) begin
                                r_axis <= r_axis + 1'b1;
                            end else begin
                                r_axis <= AXIS_X;
                                if (r_row != AXIS_Z) begin
                                    r_row <= r_row + 1'b1;
                                end else begin
                                    r_row <= AXIS_X;
                                    r_bin <= r_bin + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_RD_OUT);
    assign o_m_tlast  = last_rd;
    assign o_m_tuser  = {r_axis, r_row, r_bin};
    assign o_m_tdata  = {r_cnt, sat64({rd_im, 1'b0}), sat64({rd_re, 1'b0})};

    // a beat never goes out while a new item can be taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready during output beat");

    // accumulator writes only follow multiplies of a sample run
    a_wr_in_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_v |-> (r_state == ST_SAMPLE || r_state == ST_FLUSH))
        else $error("accumulator write outside sample run");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph <= PH_LAST)
        else $error("slot phase out of range");

    // last sample slot leads to flush; resonator pairs update once per slot, at the p2 subtract
    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMPLE && r_ph == PH_LAST && last_slot) |=> r_state == ST_FLUSH)
        else $error("sample run did not flush");

endmodule
`default_nettype wire

### sv/gcsa_mac.sv
`default_nettype none
// shared multiplier with registered product; rounding and saturation taps
module gcsa_mac #(
    parameter int A_W = 18,
    parameter int B_W = 48
) (
    input  wire logic                 i_clk,
    input  wire logic signed [A_W-1:0] i_a,
    input  wire logic signed [B_W-1:0] i_b,
    input  wire logic                 i_neg,
    output logic signed [B_W-1:0]     o_r15,
    output logic signed [B_W-1:0]     o_r16,
    output logic signed [63:0]        o_p64
);
    import gcsa_pkg::*;

    localparam int PW = A_W + B_W;
    localparam int XW = (PW + 1 > 65) ? PW + 1 : 65;

    logic signed [PW-1:0] r_prod;
    logic                 r_neg;
    logic signed [PW:0]   pe, mg, m15, m16, v15, v16, pn;
    logic signed [XW-1:0] px;

    function automatic logic signed [B_W-1:0] sat_b(input logic signed [PW:0] v);
        logic [PW-B_W+1:0] top;
        top = v[PW:B_W-1];
        if (&top || ~|top) begin
            return v[B_W-1:0];
        end
        return v[PW] ? {1'b1, {(B_W-1){1'b0}}} : {1'b0, {(B_W-1){1'b1}}};
    endfunction

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_neg  <= i_neg;
    end

    // magnitude rounding: half away from zero
    always_comb begin
        pe  = (PW+1)'(r_prod);
        mg  = pe[PW] ? -pe : pe;
        m15 = (mg + ((PW+1)'(1) <<< 14)) >>> 15;
        m16 = (mg + ((PW+1)'(1) <<< 15)) >>> 16;
        v15 = pe[PW] ? -m15 : m15;
        v16 = pe[PW] ? -m16 : m16;
        pn  = r_neg ? -pe : pe;
        px  = XW'(pn);
    end

    assign o_r15 = sat_b(v15);
    assign o_r16 = sat_b(v16);

    always_comb begin
        if (&px[XW-1:63] || ~|px[XW-1:63]) begin
            o_p64 = px[63:0];
        end else begin
            o_p64 = px[XW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

endmodule
`default_nettype wire

### sv/gcsa_accmem.sv
`default_nettype none
// covariance accumulator store, real and imaginary halves, shared read address
module gcsa_accmem #(
    parameter int DEPTH = 36,
    parameter int AW    = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gcsa_pkg::t_acc_ctl  i_ctl,
    input  wire logic [AW-1:0]       i_rd_addr,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire logic signed [63:0]  i_wr_data,
    output logic signed [63:0]       o_rd_re,
    output logic signed [63:0]       o_rd_im
);
    import gcsa_pkg::*;

    logic signed [63:0] r_mem_re [DEPTH];
    logic signed [63:0] r_mem_im [DEPTH];
    logic [DEPTH-1:0]   r_vld_re, r_vld_im;
    logic signed [63:0] r_rd_re, r_rd_im;
    logic               r_rv_re, r_rv_im;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && !i_ctl.wr_im) begin
            r_mem_re[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.wr && i_ctl.wr_im) begin
            r_mem_im[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_re <= r_mem_re[i_rd_addr];
            r_rd_im <= r_mem_im[i_rd_addr];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld_re <= '0;
            r_vld_im <= '0;
            r_rv_re  <= 1'b0;
            r_rv_im  <= 1'b0;
        end else begin
            if (i_ctl.wr && !i_ctl.wr_im) begin
                r_vld_re[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.wr && i_ctl.wr_im) begin
                r_vld_im[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rv_re <= r_vld_re[i_rd_addr];
                r_rv_im <= r_vld_im[i_rd_addr];
            end
        end
    end

    assign o_rd_re = r_rv_re ? r_rd_re : 64'sd0;
    assign o_rd_im = r_rv_im ? r_rd_im : 64'sd0;

endmodule
`default_nettype wire
